### hdl/two_light_fade_and_blink_sequencer_core_assert.svh
// assertion macros for the two-light fade and blink sequencer
// used by the top level; needs nothing else
`ifndef TWO_LIGHT_FADE_AND_BLINK_SEQUENCER_CORE_ASSERT_SVH
`define TWO_LIGHT_FADE_AND_BLINK_SEQUENCER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TLFB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("tlfb assertion failed");

// next-cycle implication, checked out of reset
`define TLFB_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("tlfb assertion failed");

`endif

### hdl/tlfb_pkg.sv
// types, codes and reset constants of the two-light fade and blink sequencer
// used by tlfb_step and the top level; depends on nothing
package tlfb_pkg;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_FADE = 2'd1,
    MODE_WAIL = 2'd2,
    MODE_HOLD = 2'd3
  } tlfb_mode_e;

  typedef enum logic [2:0] {
    REG_RISE_STEP   = 3'd0,
    REG_FALL_STEP   = 3'd1,
    REG_FULL_LEVEL  = 3'd2,
    REG_BLINK_ON    = 3'd3,
    REG_BLINK_OFF   = 3'd4,
    REG_BLINKS_SIDE = 3'd5
  } tlfb_reg_e;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 8;

  localparam logic [7:0] RiseStepRst   = 8'd18;
  localparam logic [7:0] FallStepRst   = 8'd9;
  localparam logic [7:0] FullLevelRst  = 8'd255;
  localparam logic [7:0] BlinkOnRst    = 8'd3;
  localparam logic [7:0] BlinkOffRst   = 8'd6;
  localparam logic [3:0] BlinksSideRst = 4'd3;

  typedef struct packed {
    logic [7:0] rise_step;
    logic [7:0] fall_step;
    logic [7:0] full_level;
    logic [7:0] lit_ticks;
    logic [7:0] dark_ticks;
    logic [3:0] blinks_per_side;
  } tlfb_cfg_t;

  typedef struct packed {
    logic [7:0] fade_level;
    logic       fade_rising;
    logic       fade_light_sel;
    logic       wail_light_sel;
    logic [3:0] blink_number;
    logic       blink_lit;
    logic [7:0] phase_ticks;
  } tlfb_state_t;

  localparam tlfb_state_t StateRst = '{
    fade_level:     8'd0,
    fade_rising:    1'b1,
    fade_light_sel: 1'b0,
    wail_light_sel: 1'b0,
    blink_number:   4'd0,
    blink_lit:      1'b1,
    phase_ticks:    8'd0
  };

endpackage

### hdl/tlfb_step.sv
// one animation tick: next sequencer state and the two duty levels
// combinational; uses tlfb_pkg
module tlfb_step import tlfb_pkg::*; (
  input  tlfb_cfg_t   cfg_i,
  input  tlfb_state_t state_i,
  input  tlfb_mode_e  mode_i,
  output tlfb_state_t state_o,
  output logic        has_result_o,
  output logic [7:0]  level_first_o,
  output logic [7:0]  level_second_o
);

  logic [8:0] rise_sum;
  logic [8:0] tick_next;
  logic [4:0] blink_next;
  logic       sel;
  logic [7:0] lvl;

  assign rise_sum   = {1'b0, state_i.fade_level} + {1'b0, cfg_i.rise_step};
  assign tick_next  = {1'b0, state_i.phase_ticks} + 9'd1;
  assign blink_next = {1'b0, state_i.blink_number} + 5'd1;

  always_comb begin
    state_o      = state_i;
    has_result_o = 1'b1;
    sel          = 1'b0;
    lvl          = 8'd0;
    unique case (mode_i)
      MODE_OFF: begin
        state_o = StateRst;
      end
      MODE_FADE: begin
        if (state_i.fade_rising) begin
          if (rise_sum >= {1'b0, cfg_i.full_level}) begin
            state_o.fade_level  = cfg_i.full_level;
            state_o.fade_rising = 1'b0;
          end else begin
            state_o.fade_level = rise_sum[7:0];
          end
        end else if (state_i.fade_level <= cfg_i.fall_step) begin
          state_o.fade_level     = 8'd0;
          state_o.fade_rising    = 1'b1;
          state_o.fade_light_sel = ~state_i.fade_light_sel;
        end else begin
          state_o.fade_level = state_i.fade_level - cfg_i.fall_step;
        end
        // fade shows the level after the step
        sel = state_o.fade_light_sel;
        lvl = state_o.fade_level;
      end
      MODE_WAIL: begin
        // blink shows the phase before the step
        sel = state_i.wail_light_sel;
        lvl = state_i.blink_lit ? cfg_i.full_level : 8'd0;
        state_o.phase_ticks = tick_next[7:0];
        if (state_i.blink_lit) begin
          if (tick_next >= {1'b0, cfg_i.lit_ticks}) begin
            state_o.phase_ticks = 8'd0;
            state_o.blink_lit   = 1'b0;
          end
        end else if (tick_next >= {1'b0, cfg_i.dark_ticks}) begin
          state_o.phase_ticks = 8'd0;
          state_o.blink_lit   = 1'b1;
          if (blink_next >= {1'b0, cfg_i.blinks_per_side}) begin
            state_o.blink_number   = 4'd0;
            state_o.wail_light_sel = ~state_i.wail_light_sel;
          end else begin
            state_o.blink_number = blink_next[3:0];
          end
        end
      end
      MODE_HOLD: begin
        has_result_o = 1'b0;
      end
      default: begin
        has_result_o = 1'b0;
      end
    endcase
  end

  assign level_first_o  = sel ? 8'd0 : lvl;
  assign level_second_o = sel ? lvl : 8'd0;

endmodule

### hdl/two_light_fade_and_blink_sequencer_core.sv
// top level of the two-light fade and blink sequencer
// uses tlfb_pkg, tlfb_step and two_light_fade_and_blink_sequencer_core_assert.svh
//
// Usage: each input transaction is one animation tick carrying anim_mode_i
// (off, fade, wail blink, hold). Off, fade and wail ticks each give one
// output transaction with the duty levels of both lights; a hold tick
// keeps the state and gives no output transaction.
// The result of a tick is registered and valid in the cycle after it is accepted.
// Throughput: one tick per cycle unless the receiver stalls; the tick
// logic sits between the input port and a single output register, and
// the sequencer state is updated at the same edge that loads that register.
// Stall: in_ready_o is high while the output register is empty or being
// taken in the same cycle; while the receiver stalls, the result holds
// and no new tick is taken.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i;
// write only while no tick is in flight. Indexes beyond the last
// register are ignored.
// Reset: registers take their default values, the sequencer state is
// cleared and the output register is empty.
module two_light_fade_and_blink_sequencer_core import tlfb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          anim_mode_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          level_first_o,
  output logic [7:0]          level_second_o
);

`include "two_light_fade_and_blink_sequencer_core_assert.svh"

  tlfb_cfg_t   cfg_q;
  tlfb_state_t state_q, state_d, step_state;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  level_first_q, level_second_q;
  logic        step_result;
  logic [7:0]  step_first, step_second;
  logic        in_fire;
  tlfb_mode_e  mode;

  assign mode       = tlfb_mode_e'(anim_mode_i);
  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign in_fire    = in_valid_i & in_ready_o;

  tlfb_step u_step (
    .cfg_i          (cfg_q),
    .state_i        (state_q),
    .mode_i         (mode),
    .state_o        (step_state),
    .has_result_o   (step_result),
    .level_first_o  (step_first),
    .level_second_o (step_second)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rise_step       <= RiseStepRst;
      cfg_q.fall_step       <= FallStepRst;
      cfg_q.full_level      <= FullLevelRst;
      cfg_q.lit_ticks       <= BlinkOnRst;
      cfg_q.dark_ticks      <= BlinkOffRst;
      cfg_q.blinks_per_side <= BlinksSideRst;
    end else if (cfg_we_i) begin
      unique case (tlfb_reg_e'(cfg_idx_i))
        REG_RISE_STEP:   cfg_q.rise_step       <= cfg_data_i;
        REG_FALL_STEP:   cfg_q.fall_step       <= cfg_data_i;
        REG_FULL_LEVEL:  cfg_q.full_level      <= cfg_data_i;
        REG_BLINK_ON:    cfg_q.lit_ticks       <= cfg_data_i;
        REG_BLINK_OFF:   cfg_q.dark_ticks      <= cfg_data_i;
        REG_BLINKS_SIDE: cfg_q.blinks_per_side <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    if (in_fire) begin
      state_d = step_state;
      if (step_result) begin
        out_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateRst;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload only loads on a transaction that gives a result
  always_ff @(posedge clk_i) begin
    if (in_fire && step_result) begin
      level_first_q  <= step_first;
      level_second_q <= step_second;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign level_first_o  = level_first_q;
  assign level_second_o = level_second_q;

  `TLFB_ASSERT_IMP(a_stall_blocks_input, clk_i, rst_ni, out_valid_o && !out_ready_i, !in_ready_o)
  `TLFB_ASSERT_NXT(a_off_gives_zero, clk_i, rst_ni, in_fire && mode == MODE_OFF,
                   out_valid_o && level_first_o == 8'd0 && level_second_o == 8'd0)
  `TLFB_ASSERT_NXT(a_hold_no_result, clk_i, rst_ni,
                   in_fire && mode == MODE_HOLD && (!out_valid_o || out_ready_i), !out_valid_o)
  `TLFB_ASSERT_IMP(a_one_light_lit, clk_i, rst_ni, out_valid_o,
                   level_first_o == 8'd0 || level_second_o == 8'd0)

endmodule

### sim/tb_two_light_fade_and_blink_sequencer_core.sv
// self-checking testbench for two_light_fade_and_blink_sequencer_core
// predicts both duty levels per tick in a scoreboard class; uses tlfb_pkg only
module tb_two_light_fade_and_blink_sequencer_core import tlfb_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldOffCycles = 400;

  typedef struct packed {
    logic [7:0] lvl_first;
    logic [7:0] lvl_second;
  } light_levels_t;

  class light_level_scoreboard;
    tlfb_cfg_t     cfg;
    tlfb_state_t   st;
    light_levels_t levels_due[$];
    int            mismatches;

    function new();
      cfg = '{rise_step: RiseStepRst, fall_step: FallStepRst, full_level: FullLevelRst,
              lit_ticks: BlinkOnRst, dark_ticks: BlinkOffRst,
              blinks_per_side: BlinksSideRst};
      st = StateRst;
      mismatches = 0;
    endfunction

    function void write_reg(tlfb_reg_e idx, logic [7:0] val);
      case (idx)
        REG_RISE_STEP:   cfg.rise_step = val;
        REG_FALL_STEP:   cfg.fall_step = val;
        REG_FULL_LEVEL:  cfg.full_level = val;
        REG_BLINK_ON:    cfg.lit_ticks = val;
        REG_BLINK_OFF:   cfg.dark_ticks = val;
        REG_BLINKS_SIDE: cfg.blinks_per_side = val[3:0];
        default: ;
      endcase
    endfunction

    // advance the sequencer by one accepted tick and queue its levels
    function void note_tick(tlfb_mode_e mode);
      logic [8:0]    sum;
      logic [8:0]    ticks;
      logic [4:0]    count;
      logic [7:0]    lvl;
      light_levels_t res;
      case (mode)
        MODE_OFF: begin
          st = StateRst;
          levels_due.push_back('0);
        end
        MODE_FADE: begin
          if (st.fade_rising) begin
            sum = {1'b0, st.fade_level} + {1'b0, cfg.rise_step};
            if (sum >= {1'b0, cfg.full_level}) begin
              st.fade_level = cfg.full_level;
              st.fade_rising = 1'b0;
            end else begin
              st.fade_level = sum[7:0];
            end
          end else if (st.fade_level <= cfg.fall_step) begin
            st.fade_level = 8'd0;
            st.fade_rising = 1'b1;
            st.fade_light_sel = ~st.fade_light_sel;
          end else begin
            st.fade_level = st.fade_level - cfg.fall_step;
          end
          res = st.fade_light_sel ? {8'd0, st.fade_level} : {st.fade_level, 8'd0};
          levels_due.push_back(res);
        end
        MODE_WAIL: begin
          // levels come from the state before the tick
          lvl = st.blink_lit ? cfg.full_level : 8'd0;
          res = st.wail_light_sel ? {8'd0, lvl} : {lvl, 8'd0};
          levels_due.push_back(res);
          ticks = {1'b0, st.phase_ticks} + 9'd1;
          if (st.blink_lit) begin
            if (ticks >= {1'b0, cfg.lit_ticks}) begin
              ticks = '0;
              st.blink_lit = 1'b0;
            end
          end else if (ticks >= {1'b0, cfg.dark_ticks}) begin
            count = {1'b0, st.blink_number} + 5'd1;
            ticks = '0;
            if (count >= {1'b0, cfg.blinks_per_side}) begin
              st.blink_number = 4'd0;
              st.wail_light_sel = ~st.wail_light_sel;
            end else begin
              st.blink_number = count[3:0];
            end
            st.blink_lit = 1'b1;
          end
          st.phase_ticks = ticks[7:0];
        end
        default: ;
      endcase
    endfunction

    function void check_levels(logic [7:0] got_first, logic [7:0] got_second);
      light_levels_t want;
      if (levels_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output transaction: first %0d second %0d",
                   got_first, got_second);
        return;
      end
      want = levels_due.pop_front();
      if (want.lvl_first !== got_first || want.lvl_second !== got_second) begin
        mismatches++;
        if (mismatches <= 10)
          $display("level mismatch: expected first %0d second %0d, got first %0d second %0d",
                   want.lvl_first, want.lvl_second, got_first, got_second);
      end
    endfunction

    function int pending();
      return levels_due.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [1:0]          anim_mode_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [7:0]          level_first_o;
  logic [7:0]          level_second_o;

  light_level_scoreboard sb;
  bit          hold_off_go;
  bit          hold_off_done;
  int unsigned cycles;

  two_light_fade_and_blink_sequencer_core dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .anim_mode_i,
    .out_valid_o,
    .out_ready_i,
    .level_first_o,
    .level_second_o
  );

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("two_light_fade_and_blink_sequencer_core test failed");
      $finish;
    end
  end

  function automatic logic [7:0] pick_level(bit allow_zero);
    case ($urandom_range(0, 7))
      0: return 8'd1;
      1: return 8'd255;
      2: return allow_zero ? 8'd0 : 8'd2;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  // tick counts mostly small so blinks and side swaps happen often
  function automatic logic [7:0] pick_ticks(bit allow_zero);
    case ($urandom_range(0, 9))
      0: return 8'd1;
      1: return 8'($urandom_range(200, 255));
      2: return allow_zero ? 8'd0 : 8'd1;
      default: return 8'($urandom_range(1, 6));
    endcase
  endfunction

  task automatic load_config(input tlfb_cfg_t c, input logic [3:0] side_pad);
    tlfb_reg_e  r;
    logic [7:0] v;
    r = r.first();
    do begin
      case (r)
        REG_RISE_STEP:   v = c.rise_step;
        REG_FALL_STEP:   v = c.fall_step;
        REG_FULL_LEVEL:  v = c.full_level;
        REG_BLINK_ON:    v = c.lit_ticks;
        REG_BLINK_OFF:   v = c.dark_ticks;
        default:         v = {side_pad, c.blinks_per_side};
      endcase
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= r;
      cfg_data_i <= v;
      @(posedge clk_i);
      sb.write_reg(r, v);
      r = r.next();
    end while (r != r.first());
    cfg_we_i <= 1'b0;
  endtask

  task automatic offer_tick(input tlfb_mode_e m);
    in_valid_i  <= 1'b1;
    anim_mode_i <= m;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_tick(m);
  endtask

  task automatic run_ticks(input tlfb_mode_e seq[$], input bit gappy);
    int burst;
    burst = $urandom_range(1, 24);
    foreach (seq[i]) begin
      if (gappy && burst == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        burst = $urandom_range(1, 24);
      end
      offer_tick(seq[i]);
      burst--;
    end
    in_valid_i <= 1'b0;
  endtask

  // hold ticks give no result, so the drain also waits on after the queue empties
  task automatic drain();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // receiver: stall pattern redrawn from four styles, one long hold-off on request
  initial begin
    int unsigned style;
    int unsigned tick_cnt;
    bit          rdy;
    out_ready_i = 1'b0;
    style = 0;
    tick_cnt = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i)
        sb.check_levels(level_first_o, level_second_o);
      if (hold_off_go && !hold_off_done) begin
        hold_off_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
      end
      tick_cnt++;
      if (tick_cnt % 64 == 0) style = $urandom_range(0, 3);
      case (style)
        0: rdy = 1'b1;
        1: rdy = $urandom_range(0, 1);
        2: rdy = (tick_cnt % 4 == 0);
        default: rdy = ($urandom_range(0, 3) == 0);
      endcase
      out_ready_i <= rdy;
    end
  end

  initial begin
    tlfb_cfg_t  c;
    tlfb_mode_e seq[$];
    tlfb_mode_e m;
    int         n_items;
    int         run;
    int         pick;
    bit         zero_ok;
    logic [3:0] pad;

    sb = new();
    cycles = 0;
    hold_off_go = 1'b0;
    hold_off_done = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    anim_mode_i = MODE_OFF;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset register values, every mode, hold in the middle of a fade
    seq = {MODE_OFF, MODE_FADE, MODE_FADE, MODE_HOLD, MODE_FADE, MODE_WAIL, MODE_WAIL,
           MODE_WAIL, MODE_WAIL, MODE_HOLD, MODE_OFF};
    run_ticks(seq, 1'b0);
    drain();

    // largest steps: clamp at full in one tick, fall to zero in one tick
    c = '{rise_step: 8'd255, fall_step: 8'd255, full_level: 8'd255,
          lit_ticks: 8'd1, dark_ticks: 8'd1, blinks_per_side: 4'd1};
    load_config(c, 4'd0);
    seq = {MODE_FADE, MODE_FADE, MODE_FADE, MODE_WAIL, MODE_WAIL, MODE_WAIL, MODE_WAIL};
    run_ticks(seq, 1'b0);
    drain();

    // smallest steps and level, longest blinks
    c = '{rise_step: 8'd1, fall_step: 8'd1, full_level: 8'd1,
          lit_ticks: 8'd255, dark_ticks: 8'd255, blinks_per_side: 4'd15};
    load_config(c, 4'hf);
    seq = {MODE_FADE, MODE_FADE, MODE_FADE, MODE_WAIL, MODE_WAIL, MODE_OFF};
    run_ticks(seq, 1'b0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      zero_ok = (ph == 5);
      c.rise_step       = pick_level(zero_ok);
      c.fall_step       = pick_level(zero_ok);
      c.full_level      = pick_level(zero_ok);
      c.lit_ticks       = pick_ticks(zero_ok);
      c.dark_ticks      = pick_ticks(zero_ok);
      if (zero_ok && $urandom_range(0, 1) == 1)
        c.blinks_per_side = 4'd0;
      else if ($urandom_range(0, 3) == 0)
        c.blinks_per_side = 4'($urandom_range(1, 15));
      else
        c.blinks_per_side = 4'($urandom_range(1, 4));
      pad = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(1, 15)) : 4'd0;
      load_config(c, pad);

      // long runs of one mode reach clamps, swaps and blink counts
      seq.delete();
      n_items = $urandom_range(70, 110);
      while (seq.size() < n_items) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
          m = MODE_OFF;
          run = 1;
        end else if (pick < 13) begin
          m = MODE_HOLD;
          run = $urandom_range(1, 3);
        end else if (pick < 56) begin
          m = MODE_FADE;
          run = $urandom_range(1, 40);
        end else begin
          m = MODE_WAIL;
          run = $urandom_range(1, 40);
        end
        repeat (run) seq.push_back(m);
      end
      if (ph == 2) hold_off_go = 1'b1;
      run_ticks(seq, $urandom_range(0, 3) != 0);
      drain();
    end

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("two_light_fade_and_blink_sequencer_core test passed");
    else
      $display("two_light_fade_and_blink_sequencer_core test failed");
    $finish;
  end

endmodule
